// ===== hw/rtl/pic_pkg.sv =====
// shared types, constants and saturation helpers for the particle integrator
`timescale 1ns / 1ps
package pic_pkg;

    // op codes of an input word
    localparam logic [1:0] OP_UPDATE = 2'd0;
    localparam logic [1:0] OP_PULL   = 2'd1;
    localparam logic [1:0] OP_PLACE  = 2'd2;
    localparam logic [1:0] OP_NOP    = 2'd3;

    // register indexes (byte address bits [3:2])
    localparam logic [1:0] REG_MAX_SPEED     = 2'd0;
    localparam logic [1:0] REG_DECAY         = 2'd1;
    localparam logic [1:0] REG_PULL_RADIUS   = 2'd2;
    localparam logic [1:0] REG_PULL_STRENGTH = 2'd3;

    // register reset values
    localparam logic [30:0] MAX_SPEED_RST     = 31'd262144;
    localparam logic [16:0] DECAY_RST         = 17'd62259;
    localparam logic [30:0] PULL_RADIUS_RST   = 31'd6553600;
    localparam logic [16:0] PULL_STRENGTH_RST = 17'd655;

    // request to the shared root / divide unit
    typedef struct packed {
        logic start;
        logic is_sqrt;
    } pic_iter_req_t;

    // magnitude of a signed 32 bit value
    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        logic [31:0] m;
        m = v[31] ? (~v + 32'd1) : v;
        return m;
    endfunction

    // saturate a wide signed value to 32 bits
    function automatic logic signed [31:0] sat35(input logic signed [34:0] v);
        logic signed [31:0] r;
        if (v > 35'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -35'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    // apply a sign to a magnitude, then saturate
    function automatic logic signed [31:0] sat_mag(input logic neg, input logic [32:0] m);
        logic signed [34:0] s;
        s = neg ? -$signed({2'b00, m}) : $signed({2'b00, m});
        return sat35(s);
    endfunction

endpackage

// ===== hw/rtl/pic_item_if.sv =====
// channel carrying one input word: op and vector
`timescale 1ns / 1ps
interface pic_item_if;
    logic              valid;
    logic              ready;
    logic [1:0]        op;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;

    modport source (output valid, op, vec_x, vec_y, vec_z, input ready);
    modport sink   (input valid, op, vec_x, vec_y, vec_z, output ready);
endinterface

// ===== hw/rtl/pic_result_if.sv =====
// channel carrying one result word: position and acted flag
`timescale 1ns / 1ps
interface pic_result_if;
    logic              valid;
    logic              ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic              acted;

    modport source (output valid, pos_x, pos_y, pos_z, acted, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, acted, output ready);
endinterface

// ===== hw/rtl/pic_iter.sv =====
// shared iterative unit: 64 bit floor square root or 64/32 divide, one bit per cycle
`timescale 1ns / 1ps
module pic_iter (
    input  logic                   clk,
    input  logic                   rst_n,
    input  pic_pkg::pic_iter_req_t req,
    input  logic [63:0]            a,
    input  logic [31:0]            d,
    output logic                   done,
    output logic [31:0]            result
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        sqrt_reg;
    logic [63:0] a_reg, a_next;
    logic [63:0] b_reg, b_next;
    logic [63:0] c_reg, c_next;

    logic [63:0] trial;
    logic        root_ge;
    logic [32:0] shifted;
    logic        div_ge;
    logic [32:0] shifted_sub;

    // one step of either algorithm
    always_comb
    begin
        trial       = b_reg + c_reg;
        root_ge     = (a_reg >= trial);
        shifted     = {a_reg[63:32], a_reg[31]};
        div_ge      = (shifted >= {1'b0, c_reg[31:0]});
        shifted_sub = div_ge ? (shifted - {1'b0, c_reg[31:0]}) : shifted;
        if (sqrt_reg)
        begin
            a_next = root_ge ? (a_reg - trial) : a_reg;
            b_next = root_ge ? ((b_reg >> 1) + c_reg) : (b_reg >> 1);
            c_next = c_reg >> 2;
        end
        else
        begin
            a_next = {shifted_sub[31:0], a_reg[30:0], 1'b0};
            b_next = {b_reg[62:0], div_ge};
            c_next = c_reg;
        end
    end

    // step counter and busy flag
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            sqrt_reg <= req.is_sqrt;
            a_reg    <= a;
            b_reg    <= '0;
            c_reg    <= req.is_sqrt ? 64'h4000_0000_0000_0000 : {32'd0, d};
        end
        else if (busy_reg)
        begin
            a_reg <= a_next;
            b_reg <= b_next;
            c_reg <= c_next;
        end
    end

    assign done   = done_reg;
    assign result = b_reg[31:0];

endmodule

// ===== hw/rtl/particle_integrate_clamp_pull_core.sv =====
// top level: one Q16.16 particle with speed clamp, decay and pull, APB registers
//
// One word is taken at a time; ready stays low until its result has been
// formed. A place or no-op word goes straight to its result. An update or a
// pull first sums three squares; a pull then takes a square root, and an
// update that clamps or a pull beyond the radius takes a square root and
// three quotients. The long cases are set by the shared root / divide unit,
// which resolves one result bit per cycle, so that each square root and each
// quotient holds the sequencer until it finishes, and by the single
// 32x32 multiplier used for every product. A finished result sits in an
// output register, so the next word can be taken while it waits; a word that
// finishes while that register is still full waits until it is read.
`timescale 1ns / 1ps
module particle_integrate_clamp_pull_core (
    input  logic        clk,
    input  logic        rst_n,
    pic_item_if.sink    item,
    pic_result_if.source result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [4:0] S_IDLE      = 5'd0;
    localparam logic [4:0] S_PREP      = 5'd1;
    localparam logic [4:0] S_SQ_MUL    = 5'd2;
    localparam logic [4:0] S_SQ_ACC    = 5'd3;
    localparam logic [4:0] S_LIM_MUL   = 5'd4;
    localparam logic [4:0] S_LIM_CMP   = 5'd5;
    localparam logic [4:0] S_ROOT_GO   = 5'd6;
    localparam logic [4:0] S_ROOT_WAIT = 5'd7;
    localparam logic [4:0] S_SCALE_MUL = 5'd8;
    localparam logic [4:0] S_DIV_GO    = 5'd9;
    localparam logic [4:0] S_DIV_WAIT  = 5'd10;
    localparam logic [4:0] S_PULL_MUL  = 5'd11;
    localparam logic [4:0] S_PULL_WR   = 5'd12;
    localparam logic [4:0] S_POS       = 5'd13;
    localparam logic [4:0] S_DEC_MUL   = 5'd14;
    localparam logic [4:0] S_DEC_WR    = 5'd15;
    localparam logic [4:0] S_DONE      = 5'd16;

    // configuration registers
    logic [30:0] max_speed_reg;
    logic [16:0] decay_reg;
    logic [30:0] pull_radius_reg;
    logic [16:0] pull_strength_reg;

    // particle state and working values
    logic signed [31:0] pos_reg [3];
    logic signed [31:0] vel_reg [3];
    logic signed [31:0] w_reg   [3];
    logic signed [31:0] vec_reg [3];
    logic [1:0]         op_reg;
    logic [1:0]         idx_reg;
    logic [4:0]         state_reg;
    logic               acted_reg;
    logic [63:0]        acc_reg;
    logic [63:0]        p_reg;
    logic [31:0]        len_reg;
    logic [31:0]        excess_reg;
    logic [31:0]        q_reg;

    // output register
    logic               out_valid_reg;
    logic signed [31:0] out_pos_reg [3];
    logic               out_acted_reg;

    logic                   cfg_wr;
    logic [31:0]            mul_a;
    logic [31:0]            mul_b;
    pic_pkg::pic_iter_req_t iter_req;
    logic [63:0]            iter_a;
    logic                   iter_done;
    logic [31:0]            iter_result;
    logic                   in_take;
    logic                   out_load;
    logic [31:0]            w_mag;
    logic                   w_neg;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign in_take = item.valid & item.ready;
    assign item.ready = (state_reg == S_IDLE);
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || result.ready);
    assign w_mag = pic_pkg::mag32(w_reg[idx_reg]);
    assign w_neg = w_reg[idx_reg][31];

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_speed_reg     <= pic_pkg::MAX_SPEED_RST;
            decay_reg         <= pic_pkg::DECAY_RST;
            pull_radius_reg   <= pic_pkg::PULL_RADIUS_RST;
            pull_strength_reg <= pic_pkg::PULL_STRENGTH_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                pic_pkg::REG_MAX_SPEED:     max_speed_reg     <= pwdata[30:0];
                pic_pkg::REG_DECAY:         decay_reg         <= pwdata[16:0];
                pic_pkg::REG_PULL_RADIUS:   pull_radius_reg   <= pwdata[30:0];
                pic_pkg::REG_PULL_STRENGTH: pull_strength_reg <= pwdata[16:0];
                default:                    ;
            endcase
        end
    end

    // register reads
    always_comb
    begin
        unique case (paddr[3:2])
            pic_pkg::REG_MAX_SPEED:     prdata = {1'b0, max_speed_reg};
            pic_pkg::REG_DECAY:         prdata = {15'd0, decay_reg};
            pic_pkg::REG_PULL_RADIUS:   prdata = {1'b0, pull_radius_reg};
            pic_pkg::REG_PULL_STRENGTH: prdata = {15'd0, pull_strength_reg};
            default:                    prdata = '0;
        endcase
    end

    // shared multiplier operand select
    always_comb
    begin
        mul_a = w_mag;
        mul_b = w_mag;
        case (state_reg)
            S_LIM_MUL:
            begin
                mul_a = {1'b0, max_speed_reg};
                mul_b = {1'b0, max_speed_reg};
            end
            S_SCALE_MUL:
            begin
                mul_b = (op_reg == pic_pkg::OP_UPDATE) ? {1'b0, max_speed_reg} : excess_reg;
            end
            S_PULL_MUL:
            begin
                mul_a = q_reg;
                mul_b = {15'd0, pull_strength_reg};
            end
            S_DEC_MUL:
            begin
                mul_b = {15'd0, decay_reg};
            end
            default:
            begin
                mul_a = w_mag;
                mul_b = w_mag;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        p_reg <= mul_a * mul_b;
    end

    // root / divide requests
    always_comb
    begin
        iter_req.start   = (state_reg == S_ROOT_GO) || (state_reg == S_DIV_GO);
        iter_req.is_sqrt = (state_reg == S_ROOT_GO);
        iter_a           = (state_reg == S_ROOT_GO) ? acc_reg : p_reg;
    end

    pic_iter u_iter (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (iter_req),
        .a      (iter_a),
        .d      (len_reg),
        .done   (iter_done),
        .result (iter_result)
    );

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            for (int i = 0; i < 3; i++)
            begin
                pos_reg[i] <= '0;
                vel_reg[i] <= '0;
            end
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_take)
                        state_reg <= S_PREP;
                end
                S_PREP:
                begin
                    if (op_reg == pic_pkg::OP_PLACE)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            pos_reg[i] <= vec_reg[i];
                            vel_reg[i] <= '0;
                        end
                        state_reg <= S_DONE;
                    end
                    else if (op_reg == pic_pkg::OP_NOP)
                        state_reg <= S_DONE;
                    else
                        state_reg <= S_SQ_MUL;
                end
                S_SQ_MUL:
                    state_reg <= S_SQ_ACC;
                S_SQ_ACC:
                begin
                    if (idx_reg == 2'd2)
                        state_reg <= (op_reg == pic_pkg::OP_UPDATE) ? S_LIM_MUL : S_ROOT_GO;
                    else
                        state_reg <= S_SQ_MUL;
                end
                S_LIM_MUL:
                    state_reg <= S_LIM_CMP;
                S_LIM_CMP:
                    state_reg <= (acc_reg > p_reg) ? S_ROOT_GO : S_POS;
                S_ROOT_GO:
                    state_reg <= S_ROOT_WAIT;
                S_ROOT_WAIT:
                begin
                    if (iter_done)
                    begin
                        if (op_reg == pic_pkg::OP_UPDATE)
                            state_reg <= S_SCALE_MUL;
                        else if (iter_result > {1'b0, pull_radius_reg})
                            state_reg <= S_SCALE_MUL;
                        else
                            state_reg <= S_DONE;
                    end
                end
                S_SCALE_MUL:
                    state_reg <= S_DIV_GO;
                S_DIV_GO:
                    state_reg <= S_DIV_WAIT;
                S_DIV_WAIT:
                begin
                    if (iter_done)
                    begin
                        if (op_reg != pic_pkg::OP_UPDATE)
                            state_reg <= S_PULL_MUL;
                        else if (idx_reg == 2'd2)
                            state_reg <= S_POS;
                        else
                            state_reg <= S_SCALE_MUL;
                    end
                end
                S_PULL_MUL:
                    state_reg <= S_PULL_WR;
                S_PULL_WR:
                begin
                    vel_reg[idx_reg] <= pic_pkg::sat35(
                        35'(vel_reg[idx_reg])
                        - 35'(pic_pkg::sat_mag(1'b0, 33'd0))
                        - (w_neg ? -$signed({2'b00, p_reg[48:16]})
                                 : $signed({2'b00, p_reg[48:16]})));
                    state_reg <= (idx_reg == 2'd2) ? S_DONE : S_SCALE_MUL;
                end
                S_POS:
                begin
                    for (int i = 0; i < 3; i++)
                        pos_reg[i] <= pic_pkg::sat35(35'(pos_reg[i]) + 35'(w_reg[i]));
                    state_reg <= S_DEC_MUL;
                end
                S_DEC_MUL:
                    state_reg <= S_DEC_WR;
                S_DEC_WR:
                begin
                    vel_reg[idx_reg] <= pic_pkg::sat_mag(w_neg, p_reg[48:16]);
                    state_reg <= (idx_reg == 2'd2) ? S_DONE : S_DEC_MUL;
                end
                S_DONE:
                begin
                    if (out_load)
                        state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // working registers of the sequencer
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                op_reg     <= item.op;
                vec_reg[0] <= item.vec_x;
                vec_reg[1] <= item.vec_y;
                vec_reg[2] <= item.vec_z;
                acted_reg  <= 1'b0;
            end
            S_PREP:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (op_reg == pic_pkg::OP_UPDATE)
                        w_reg[i] <= pic_pkg::sat35(35'(vel_reg[i]) + 35'(vec_reg[i]));
                    else
                        w_reg[i] <= pic_pkg::sat35(35'(pos_reg[i]) - 35'(vec_reg[i]));
                end
                acc_reg <= '0;
                idx_reg <= '0;
            end
            S_SQ_ACC:
            begin
                acc_reg <= acc_reg + p_reg;
                idx_reg <= (idx_reg == 2'd2) ? 2'd0 : idx_reg + 2'd1;
            end
            S_ROOT_WAIT:
            begin
                if (iter_done)
                begin
                    len_reg    <= iter_result;
                    excess_reg <= iter_result - {1'b0, pull_radius_reg};
                    idx_reg    <= '0;
                    if (op_reg == pic_pkg::OP_UPDATE
                        || iter_result > {1'b0, pull_radius_reg})
                        acted_reg <= 1'b1;
                end
            end
            S_DIV_WAIT:
            begin
                if (iter_done)
                begin
                    q_reg <= iter_result;
                    if (op_reg == pic_pkg::OP_UPDATE)
                    begin
                        w_reg[idx_reg] <= pic_pkg::sat_mag(w_neg, {1'b0, iter_result});
                        idx_reg <= (idx_reg == 2'd2) ? 2'd0 : idx_reg + 2'd1;
                    end
                end
            end
            S_PULL_WR:
                idx_reg <= idx_reg + 2'd1;
            S_POS:
                idx_reg <= '0;
            S_DEC_WR:
                idx_reg <= idx_reg + 2'd1;
            default:
                ;
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            for (int i = 0; i < 3; i++)
                out_pos_reg[i] <= pos_reg[i];
            out_acted_reg <= acted_reg;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.pos_x = out_pos_reg[0];
    assign result.pos_y = out_pos_reg[1];
    assign result.pos_z = out_pos_reg[2];
    assign result.acted = out_acted_reg;

endmodule

// ===== hw/rtl/pic_checker.sv =====
// port-level checks on the particle integrator, bound to the top level
`timescale 1ns / 1ps
module pic_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out_pos_x,
    input logic        pready
);

    // a waiting result stays valid and its x position holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_pos_x))
        else $error("result word changed while stalled");

    // block is busy right after taking a word
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready stayed high after a word was taken");

    // ready only drops because a word was taken
    a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_ready) |-> $past(in_valid))
        else $error("ready dropped with no word taken");

    // register port never waits
    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");

endmodule

bind particle_integrate_clamp_pull_core pic_checker u_pic_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_pos_x (result.pos_x),
    .pready    (pready)
);
